// ===== rtl/core/circle_rect_collision_resolve_core_assert.svh =====
// Assertion shorthands for the collision resolve core.
// The enclosing module must provide clk and rst.
`ifndef CIRCLE_RECT_COLLISION_RESOLVE_CORE_ASSERT_SVH
`define CIRCLE_RECT_COLLISION_RESOLVE_CORE_ASSERT_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define CRC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collision resolve core: implication violated");

// cond must hold at every clock edge outside reset.
`define CRC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("collision resolve core: invariant violated");

`endif

// ===== rtl/core/crc_pkg.sv =====
package crc_pkg;

  localparam int CoordW = 24;
  localparam int SqW    = 2 * CoordW;
  localparam int NumW   = 2 * CoordW - 1;
  // Front stages, root cells, post, multiply, rounding add, quotient cells, output.
  localparam int Lat    = 5 + CoordW + 3 + (CoordW - 1) + 1;

  localparam logic [1:0] FaceNone      = 2'd0;
  localparam logic [1:0] FaceTopBottom = 2'd1;
  localparam logic [1:0] FaceSide      = 2'd2;

  localparam logic signed [CoordW:0] CoordMax = (CoordW + 1)'(2 ** (CoordW - 1) - 1);
  localparam logic signed [CoordW:0] CoordMin = -(CoordW + 1)'(2 ** (CoordW - 1));

  typedef struct packed {
    logic signed [CoordW-1:0] disc_x;
    logic signed [CoordW-1:0] disc_y;
    logic        [CoordW-2:0] disc_radius;
    logic signed [CoordW-1:0] box_x;
    logic signed [CoordW-1:0] box_y;
    logic        [CoordW-2:0] box_width;
    logic        [CoordW-2:0] box_height;
  } item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic        [1:0]        contact_face;
  } result_t;

  // Per-transaction context carried down both cell chains.
  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic        [CoordW-2:0] r;
    logic                     sx;
    logic                     sy;
    logic                     elig;
  } ctx_t;

  typedef struct packed {
    logic                     vld;
    ctx_t                     ctx;
    logic        [CoordW-2:0] ax;
    logic        [CoordW-2:0] ay;
    logic        [SqW-1:0]    s;
    logic        [CoordW+3:0] rem;
    logic        [CoordW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                     vld;
    ctx_t                     ctx;
    logic                     contact;
    logic        [1:0]        face;
    logic        [CoordW-2:0] divisor;
    logic        [CoordW-2:0] nx;
    logic        [CoordW-2:0] ny;
    logic        [CoordW-2:0] remx;
    logic        [CoordW-2:0] remy;
    logic        [CoordW-2:0] qx;
    logic        [CoordW-2:0] qy;
  } div_t;

endpackage

// ===== rtl/core/crc_sqrt_cell.sv =====
module crc_sqrt_cell import crc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  sqrt_t a,
  output sqrt_t b
);

  logic [CoordW+3:0] rem_sh;
  logic [CoordW+3:0] trial;
  sqrt_t             b_next;

  // One root bit per cell: bring down two radicand bits and try root*4+1.
  always_comb begin
    rem_sh = {a.rem[CoordW+1:0], a.s[SqW-1 -: 2]};
    trial  = {2'b00, a.root, 2'b01};
    b_next = a;
    b_next.s = {a.s[SqW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      b_next.rem  = rem_sh - trial;
      b_next.root = {a.root[CoordW-2:0], 1'b1};
    end else begin
      b_next.rem  = rem_sh;
      b_next.root = {a.root[CoordW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    b <= b_next;
    if (rst) begin
      b.vld <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/crc_div_cell.sv =====
module crc_div_cell import crc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_t a,
  output div_t b
);

  logic [CoordW-1:0] tx;
  logic [CoordW-1:0] ty;
  logic [CoordW-1:0] dv;
  logic              gex;
  logic              gey;
  logic [CoordW-1:0] subx;
  logic [CoordW-1:0] suby;
  div_t              b_next;

  // One quotient bit per axis per cell, restoring form.
  always_comb begin
    dv   = {1'b0, a.divisor};
    tx   = {a.remx, a.nx[CoordW-2]};
    ty   = {a.remy, a.ny[CoordW-2]};
    gex  = tx >= dv;
    gey  = ty >= dv;
    subx = tx - dv;
    suby = ty - dv;
    b_next      = a;
    b_next.nx   = {a.nx[CoordW-3:0], 1'b0};
    b_next.ny   = {a.ny[CoordW-3:0], 1'b0};
    b_next.remx = gex ? subx[CoordW-2:0] : tx[CoordW-2:0];
    b_next.remy = gey ? suby[CoordW-2:0] : ty[CoordW-2:0];
    b_next.qx   = {a.qx[CoordW-3:0], gex};
    b_next.qy   = {a.qy[CoordW-3:0], gey};
  end

  always_ff @(posedge clk) begin
    b <= b_next;
    if (rst) begin
      b.vld <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/circle_rect_collision_resolve_core.sv =====
// Disc versus axis-aligned rectangle contact resolution, fully pipelined.
// Input channel: an item (disc centre and radius, rectangle corner and size, all
// sharing the same fixed-point scaling) is taken on every rising edge where start is
// high and busy is low. busy is held low, so a new transaction may be issued every
// cycle, giving a throughput of one pair per clock.
// Output channel: each transaction produces exactly one result, presented on result
// for a single cycle with done high.
// The latency is set by the two cell chains: 24 integer square root cells (one root
// bit each) and 23 restoring division cells (one quotient bit per axis each), plus
// nine stages for clamping, squaring, multiplying and the final saturating add.
// Results leave in the order the transactions arrived; the receiver cannot stall
// them and must take each one in its strobe cycle.
// Reset clears every valid flag in the pipeline, dropping transactions in flight;
// no results appear until new transactions have passed through.
// out_x and out_y carry the resolved centre, saturated to the coordinate range, and
// contact_face reports no contact, a top or bottom face, or a side face.
module circle_rect_collision_resolve_core import crc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  // Stage 1: far edges of the rectangle.
  logic                     v1;
  logic signed [CoordW:0]   cx1, cy1, bx1, by1, bxw1, byh1;
  logic        [CoordW-2:0] r1;
  // Stage 2: offsets from the closest point.
  logic                     v2;
  logic signed [CoordW+1:0] dx2, dy2;
  logic signed [CoordW-1:0] cx2, cy2;
  logic        [CoordW-2:0] r2;
  // Stage 3 and 4 feed the root chain.
  logic                     v3;
  ctx_t                     ctx3;
  logic        [CoordW-2:0] ax3, ay3;
  logic                     v4;
  ctx_t                     ctx4;
  logic        [CoordW-2:0] ax4, ay4;
  logic        [SqW-3:0]    sqx4, sqy4;

  logic signed [CoordW:0]   px_c, py_c;
  logic        [CoordW+1:0] ax_c, ay_c;
  logic                     elig_c;

  sqrt_t                    sq_chain [0:CoordW];

  // Post-root, multiply and rounding stages.
  logic                     v6;
  ctx_t                     ctx6;
  logic                     contact6;
  logic        [1:0]        face6;
  logic        [CoordW-2:0] ax6, ay6, ovl6, dist6;
  logic                     v7;
  ctx_t                     ctx7;
  logic                     contact7;
  logic        [1:0]        face7;
  logic        [CoordW-2:0] dist7;
  logic        [SqW-3:0]    mx7, my7;
  logic        [NumW-1:0]   numx_c, numy_c;

  div_t                     dv_chain [0:CoordW-1];

  logic signed [CoordW:0]   sumx_c, sumy_c;
  logic signed [CoordW:0]   qxe_c, qye_c;
  logic signed [CoordW-1:0] ox_c, oy_c;
  logic        [CoordW-1:0] root_c;
  logic                     contact_c;
  div_t                     dend;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    cx1  <= (CoordW + 1)'(item.disc_x);
    cy1  <= (CoordW + 1)'(item.disc_y);
    bx1  <= (CoordW + 1)'(item.box_x);
    by1  <= (CoordW + 1)'(item.box_y);
    bxw1 <= (CoordW + 1)'(item.box_x) + $signed({2'b00, item.box_width});
    byh1 <= (CoordW + 1)'(item.box_y) + $signed({2'b00, item.box_height});
    r1   <= item.disc_radius;
    v1   <= start & ~busy;
    if (rst) begin
      v1 <= 1'b0;
    end
  end

  always_comb begin
    if (cx1 < bx1) begin
      px_c = bx1;
    end else if (cx1 > bxw1) begin
      px_c = bxw1;
    end else begin
      px_c = cx1;
    end
    if (cy1 < by1) begin
      py_c = by1;
    end else if (cy1 > byh1) begin
      py_c = byh1;
    end else begin
      py_c = cy1;
    end
  end

  always_ff @(posedge clk) begin
    dx2 <= (CoordW + 2)'(cx1) - (CoordW + 2)'(px_c);
    dy2 <= (CoordW + 2)'(cy1) - (CoordW + 2)'(py_c);
    cx2 <= cx1[CoordW-1:0];
    cy2 <= cy1[CoordW-1:0];
    r2  <= r1;
    v2  <= v1;
    if (rst) begin
      v2 <= 1'b0;
    end
  end

  // Either offset at or beyond the radius rules out contact; this also bounds the
  // squares below.
  always_comb begin
    ax_c   = dx2[CoordW+1] ? unsigned'(-dx2) : unsigned'(dx2);
    ay_c   = dy2[CoordW+1] ? unsigned'(-dy2) : unsigned'(dy2);
    elig_c = (ax_c < {3'b000, r2}) && (ay_c < {3'b000, r2});
  end

  always_ff @(posedge clk) begin
    ctx3.cx   <= cx2;
    ctx3.cy   <= cy2;
    ctx3.r    <= r2;
    ctx3.sx   <= dx2[CoordW+1];
    ctx3.sy   <= dy2[CoordW+1];
    ctx3.elig <= elig_c;
    ax3       <= elig_c ? ax_c[CoordW-2:0] : '0;
    ay3       <= elig_c ? ay_c[CoordW-2:0] : '0;
    v3        <= v2;
    if (rst) begin
      v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sqx4 <= ax3 * ax3;
    sqy4 <= ay3 * ay3;
    ax4  <= ax3;
    ay4  <= ay3;
    ctx4 <= ctx3;
    v4   <= v3;
    if (rst) begin
      v4 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sq_chain[0].s    <= {2'b00, sqx4} + {2'b00, sqy4};
    sq_chain[0].rem  <= '0;
    sq_chain[0].root <= '0;
    sq_chain[0].ax   <= ax4;
    sq_chain[0].ay   <= ay4;
    sq_chain[0].ctx  <= ctx4;
    sq_chain[0].vld  <= v4;
    if (rst) begin
      sq_chain[0].vld <= 1'b0;
    end
  end

  for (genvar i = 0; i < CoordW; i++) begin : g_sqrt
    crc_sqrt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .a   (sq_chain[i]),
      .b   (sq_chain[i+1])
    );
  end

  always_comb begin
    root_c    = sq_chain[CoordW].root;
    contact_c = sq_chain[CoordW].ctx.elig && (root_c < {1'b0, sq_chain[CoordW].ctx.r});
  end

  always_ff @(posedge clk) begin
    ctx6     <= sq_chain[CoordW].ctx;
    ax6      <= sq_chain[CoordW].ax;
    ay6      <= sq_chain[CoordW].ay;
    contact6 <= contact_c;
    ovl6     <= sq_chain[CoordW].ctx.r - root_c[CoordW-2:0];
    // A zero distance only occurs with both offsets zero; one LSB keeps the divide sane.
    dist6    <= (root_c == '0) ? (CoordW - 1)'(1) : root_c[CoordW-2:0];
    if (!contact_c) begin
      face6 <= FaceNone;
    end else if (sq_chain[CoordW].ax > sq_chain[CoordW].ay) begin
      face6 <= FaceSide;
    end else begin
      face6 <= FaceTopBottom;
    end
    v6 <= sq_chain[CoordW].vld;
    if (rst) begin
      v6 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mx7      <= ax6 * ovl6;
    my7      <= ay6 * ovl6;
    dist7    <= dist6;
    face7    <= face6;
    contact7 <= contact6;
    ctx7     <= ctx6;
    v7       <= v6;
    if (rst) begin
      v7 <= 1'b0;
    end
  end

  // Round half away from zero by adding half the divisor before dividing.
  always_comb begin
    numx_c = {1'b0, mx7} + NumW'(dist7 >> 1);
    numy_c = {1'b0, my7} + NumW'(dist7 >> 1);
  end

  always_ff @(posedge clk) begin
    dv_chain[0].ctx     <= ctx7;
    dv_chain[0].contact <= contact7;
    dv_chain[0].face    <= face7;
    dv_chain[0].divisor <= dist7;
    dv_chain[0].remx    <= numx_c[NumW-2:CoordW-1];
    dv_chain[0].remy    <= numy_c[NumW-2:CoordW-1];
    dv_chain[0].nx      <= numx_c[CoordW-2:0];
    dv_chain[0].ny      <= numy_c[CoordW-2:0];
    dv_chain[0].qx      <= '0;
    dv_chain[0].qy      <= '0;
    dv_chain[0].vld     <= v7;
    if (rst) begin
      dv_chain[0].vld <= 1'b0;
    end
  end

  for (genvar i = 0; i < CoordW - 1; i++) begin : g_div
    crc_div_cell u_cell (
      .clk (clk),
      .rst (rst),
      .a   (dv_chain[i]),
      .b   (dv_chain[i+1])
    );
  end

  always_comb begin
    dend   = dv_chain[CoordW-1];
    qxe_c  = $signed({2'b00, dend.qx});
    qye_c  = $signed({2'b00, dend.qy});
    sumx_c = (CoordW + 1)'(dend.ctx.cx) + (dend.ctx.sx ? -qxe_c : qxe_c);
    sumy_c = (CoordW + 1)'(dend.ctx.cy) + (dend.ctx.sy ? -qye_c : qye_c);
    if (sumx_c > CoordMax) begin
      ox_c = CoordMax[CoordW-1:0];
    end else if (sumx_c < CoordMin) begin
      ox_c = CoordMin[CoordW-1:0];
    end else begin
      ox_c = sumx_c[CoordW-1:0];
    end
    if (sumy_c > CoordMax) begin
      oy_c = CoordMax[CoordW-1:0];
    end else if (sumy_c < CoordMin) begin
      oy_c = CoordMin[CoordW-1:0];
    end else begin
      oy_c = sumy_c[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result.out_x        <= dend.contact ? ox_c : dend.ctx.cx;
    result.out_y        <= dend.contact ? oy_c : dend.ctx.cy;
    result.contact_face <= dend.face;
    done                <= dend.vld;
    if (rst) begin
      done <= 1'b0;
    end
  end

  `include "circle_rect_collision_resolve_core_assert.svh"

  `CRC_ASSERT_IMPLY(a_done_follows_start, done, $past(start, Lat))
  `CRC_ASSERT_IMPLY(a_face_code, done, result.contact_face != 2'd3)
  `CRC_ASSERT_IMPLY(a_no_contact_passes, done && result.contact_face == FaceNone,
                    result.out_x == $past(item.disc_x, Lat))
  `CRC_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule

// ===== tb/circle_rect_collision_resolve_core_checker.sv =====
module circle_rect_collision_resolve_core_checker import crc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    done,
  input  result_t result,
  output int      fail_count,
  output int      pending,
  output int      results_seen,
  output int      contacts_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  result_t expected_q[$];

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip64(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint floor_root(longint unsigned s);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(root);
  endfunction

  // The push on one axis is rounded to nearest, ties away from zero.
  function automatic longint push_out(longint d, longint overlap, longint span);
    longint q;
    q = (abs64(d) * overlap + span / 2) / span;
    return (d < 0) ? -q : q;
  endfunction

  function automatic result_t resolve_contact(item_t it);
    result_t res;
    longint cx, cy, r, bx, by, px, py, dx, dy, ax, ay, span, overlap, lo, hi;
    cx = longint'(it.disc_x);
    cy = longint'(it.disc_y);
    r  = longint'({1'b0, it.disc_radius});
    bx = longint'(it.box_x);
    by = longint'(it.box_y);
    px = clip64(cx, bx, bx + longint'({1'b0, it.box_width}));
    py = clip64(cy, by, by + longint'({1'b0, it.box_height}));
    dx = cx - px;
    dy = cy - py;
    ax = abs64(dx);
    ay = abs64(dy);
    lo = longint'(CoordMin);
    hi = longint'(CoordMax);
    res.out_x = it.disc_x;
    res.out_y = it.disc_y;
    res.contact_face = FaceNone;
    if (ax < r && ay < r) begin
      span = floor_root(longint'(ax * ax + ay * ay));
      if (span < r) begin
        overlap = r - span;
        if (span == 0) span = 1;
        res.out_x = CoordW'(clip64(cx + push_out(dx, overlap, span), lo, hi));
        res.out_y = CoordW'(clip64(cy + push_out(dy, overlap, span), lo, hi));
        res.contact_face = (ax > ay) ? FaceSide : FaceTopBottom;
      end
    end
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_q.delete();
      fail_count <= 0;
      results_seen <= 0;
      contacts_seen <= 0;
    end else begin
      if (done) begin
        results_seen <= results_seen + 1;
        if (result.contact_face != FaceNone) contacts_seen <= contacts_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d face=%0d", $time,
                   result.out_x, result.out_y, result.contact_face);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.out_x !== result.out_x || want.out_y !== result.out_y ||
              want.contact_face !== result.contact_face) begin
            $display("%0t: mismatch expected x=%0d y=%0d face=%0d actual x=%0d y=%0d face=%0d",
                     $time, want.out_x, want.out_y, want.contact_face,
                     result.out_x, result.out_y, result.contact_face);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Queued after the pop, so a result and a new start at the same edge are checked in order.
      if (start && !busy) expected_q.insert(expected_q.size(), resolve_contact(item));
    end
  end
endmodule

// ===== tb/circle_rect_collision_resolve_core_test.sv =====
module circle_rect_collision_resolve_core_test;
  import crc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  logic    done;
  item_t   item;
  result_t result;
  int      fail_count, pending, results_seen, contacts_seen;
  int      items_sent;
  int      gap_pct;

  circle_rect_collision_resolve_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  circle_rect_collision_resolve_core_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .contacts_seen(contacts_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [CoordW-1:0] any_coord();
    case ($urandom_range(0, 5))
      0: return CoordW'(CoordMax);
      1: return CoordW'(CoordMin);
      2: return CoordW'($urandom_range(0, 255));
      default: return CoordW'($urandom);
    endcase
  endfunction

  // Places the disc near the rectangle so most pairs touch or nearly touch.
  function automatic item_t near_pair();
    item_t it;
    int sz, off;
    sz = (1 << $urandom_range(2, 22)) - 1;
    it.disc_radius = (CoordW-1)'($urandom_range(0, sz));
    it.box_width   = (CoordW-1)'($urandom_range(0, sz));
    it.box_height  = (CoordW-1)'($urandom_range(0, sz));
    if ($urandom_range(0, 9) == 0) begin
      it.box_x = any_coord();
      it.box_y = any_coord();
    end else begin
      it.box_x = CoordW'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
      it.box_y = CoordW'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
    end
    off = int'(it.disc_radius) + 2;
    it.disc_x = it.box_x + CoordW'($urandom_range(0, int'(it.box_width) + 2 * off)) -
                CoordW'(off);
    it.disc_y = it.box_y + CoordW'($urandom_range(0, int'(it.box_height) + 2 * off)) -
                CoordW'(off);
    return it;
  endfunction

  function automatic item_t noise_pair();
    item_t it;
    it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom}));
    return it;
  endfunction

  function automatic item_t make_pair(int cx, int cy, int r, int bx, int by, int w, int h);
    item_t it;
    it.disc_x = CoordW'(cx);
    it.disc_y = CoordW'(cy);
    it.disc_radius = (CoordW-1)'(r);
    it.box_x = CoordW'(bx);
    it.box_y = CoordW'(by);
    it.box_width = (CoordW-1)'(w);
    it.box_height = (CoordW-1)'(h);
    return it;
  endfunction

  // start stays high between back-to-back transactions and drops only in idle cycles.
  task automatic send(item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    int mx, mn;
    mx = int'(CoordMax);
    mn = int'(CoordMin);
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    gap_pct = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: centre inside, each face, corners, zero radius, far offsets, saturation.
    send(make_pair(100, 100, 50, 0, 0, 200, 200));
    send(make_pair(0, 0, 0, 0, 0, 0, 0));
    send(make_pair(-10, 50, 20, 0, 0, 100, 100));
    send(make_pair(50, 110, 20, 0, 0, 100, 100));
    send(make_pair(50, -5, 20, 0, 0, 100, 100));
    send(make_pair(107, 50, 20, 0, 0, 100, 100));
    send(make_pair(105, 105, 20, 0, 0, 100, 100));
    send(make_pair(-3, -4, 6, 0, 0, 100, 100));
    send(make_pair(-3, -4, 5, 0, 0, 100, 100));
    send(make_pair(150, 50, 50, 0, 0, 100, 100));
    send(make_pair(50, 50, 0, 0, 0, 100, 100));
    send(make_pair(mx, mx, 2 ** 23 - 1, mx - 10, mx - 10, 2 ** 23 - 1, 2 ** 23 - 1));
    send(make_pair(mx, 0, 2 ** 23 - 1, mx - 5, -10, 0, 20));
    send(make_pair(mn, 0, 2 ** 23 - 1, mn + 5, -10, 0, 20));
    send(make_pair(mn, mn, 2 ** 23 - 1, mn, mn, 2 ** 23 - 1, 2 ** 23 - 1));
    send(make_pair(mx, mn, 2 ** 23 - 1, mn, mx, 0, 0));
    send(make_pair(mn + 100, 0, 2 ** 23 - 1, mn + 300, 0, 0, 0));
    send(make_pair(0, 0, 2 ** 23 - 1, 2 ** 22, 2 ** 22, 2 ** 23 - 1, 2 ** 23 - 1));
    send(make_pair(-1, -1, 1, 0, 0, 0, 0));
    send(make_pair(1, 1, 2, 0, 0, 0, 0));
    start <= 1'b0;

    // The sender waits for the pipeline to drain before the random phases.
    while (pending != 0) @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: gap_pct = 0;
        1: gap_pct = 74;
        2: gap_pct = 11;
        default: gap_pct = 0;
      endcase
      for (int n = 0; n < 325; n++) begin
        if ($urandom_range(0, 4) == 0) send(noise_pair());
        else send(near_pair());
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Lat + 20) @(posedge clk);
    $display("Sent %0d pairs; %0d results checked, %0d with contact.",
             items_sent, results_seen, contacts_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
